// ===== hw/rtl/xalu_pkg.sv =====
package xalu_pkg;

  typedef enum logic [2:0] {
    MODE_ADD = 3'd0,
    MODE_SUB = 3'd1,
    MODE_AND = 3'd2,
    MODE_OR  = 3'd3,
    MODE_XOR = 3'd4,
    MODE_MUL = 3'd5
  } mode_t;

  // Bit positions in the written-flags mask.
  localparam int unsigned FB_CARRY    = 0;
  localparam int unsigned FB_OVERFLOW = 1;
  localparam int unsigned FB_SIGN     = 2;
  localparam int unsigned FB_ZERO     = 3;
  localparam int unsigned FB_AUX      = 4;
  localparam int unsigned FB_PARITY   = 5;

  localparam logic [5:0] FW_ARITH = 6'h3f;
  localparam logic [5:0] FW_LOGIC = 6'h2f;
  localparam logic [5:0] FW_MUL   = 6'h03;
  localparam logic [5:0] FW_NONE  = 6'h00;

endpackage

// ===== hw/rtl/x86_alu_with_flags_top.sv =====
// Three-stage ALU pipeline: input register, execute (add/sub/logic and the 16x16
// multiplier), then flag evaluation into the output register.
// An accepted item passes the input, execute and output registers to reach out_valid.
// Throughput: one item per cycle; a stall at the output backs up stage by stage
// without losing or repeating an item.
// Reset (synchronous, active low) clears the stage valid bits only.
module x86_alu_with_flags_top
  import xalu_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_mode,
  input  logic        in_wide,
  input  logic [15:0] in_operand_a,
  input  logic [15:0] in_operand_b,
  input  logic        in_carry_in,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_result,
  output logic        out_flag_carry,
  output logic        out_flag_overflow,
  output logic        out_flag_sign,
  output logic        out_flag_zero,
  output logic        out_flag_aux,
  output logic        out_flag_parity,
  output logic [5:0]  out_flags_written
);

  logic en1, en2, en3;
  logic v1_r, v2_r, v3_r;

  // Stage 1: captured item.
  logic [2:0]  mode1_r;
  logic        wide1_r;
  logic [15:0] a1_r, b1_r;
  logic        cin1_r;

  // Stage 2: raw result and arithmetic flags.
  logic [31:0] res2_r, res2_nxt;
  logic        c2_r, c2_nxt;
  logic        o2_r, o2_nxt;
  logic        aux2_r, aux2_nxt;
  logic        wide2_r;
  logic        mul2_r, mul2_nxt;
  logic [5:0]  wr2_r, wr2_nxt;

  // Stage 3: output register.
  logic [31:0] res3_r;
  logic        c3_r, o3_r, s3_r, z3_r, aux3_r, p3_r;
  logic [5:0]  wr3_r;
  logic        c3_nxt, o3_nxt, s3_nxt, z3_nxt, aux3_nxt, p3_nxt;

  assign en3      = !v3_r || out_ready;
  assign en2      = !v2_r || en3;
  assign en1      = !v1_r || en2;
  assign in_ready = en1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (en1) v1_r <= in_valid;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      mode1_r <= in_mode;
      wide1_r <= in_wide;
      a1_r    <= in_operand_a;
      b1_r    <= in_operand_b;
      cin1_r  <= in_carry_in;
    end
  end

  // Execute stage.
  logic [15:0]        am, bm, rm;
  logic [16:0]        sum17, diff17;
  logic signed [31:0] prod;
  logic               at, bt, rt;

  always_comb begin
    am     = wide1_r ? a1_r : {8'h00, a1_r[7:0]};
    bm     = wide1_r ? b1_r : {8'h00, b1_r[7:0]};
    sum17  = {1'b0, am} + {1'b0, bm} + {16'h0000, cin1_r};
    diff17 = {1'b0, am} - {1'b0, bm} - {16'h0000, cin1_r};
    prod   = 32'($signed(a1_r) * $signed(b1_r));
    at     = wide1_r ? am[15] : am[7];
    bt     = wide1_r ? bm[15] : bm[7];

    res2_nxt = 32'h0;
    c2_nxt   = 1'b0;
    o2_nxt   = 1'b0;
    aux2_nxt = 1'b0;
    mul2_nxt = 1'b0;
    wr2_nxt  = FW_NONE;
    rm       = 16'h0000;
    rt       = 1'b0;

    case (mode1_r)
      MODE_ADD: begin
        rm       = wide1_r ? sum17[15:0] : {8'h00, sum17[7:0]};
        rt       = wide1_r ? rm[15] : rm[7];
        c2_nxt   = wide1_r ? sum17[16] : sum17[8];
        o2_nxt   = ~(at ^ bt) & (at ^ rt);
        aux2_nxt = am[4] ^ bm[4] ^ rm[4];
        res2_nxt = {16'h0000, rm};
        wr2_nxt  = FW_ARITH;
      end
      MODE_SUB: begin
        rm       = wide1_r ? diff17[15:0] : {8'h00, diff17[7:0]};
        rt       = wide1_r ? rm[15] : rm[7];
        // The 17-bit difference is negative exactly when a borrow occurs.
        c2_nxt   = diff17[16];
        o2_nxt   = (at ^ bt) & (at ^ rt);
        aux2_nxt = am[4] ^ bm[4] ^ rm[4];
        res2_nxt = {16'h0000, rm};
        wr2_nxt  = FW_ARITH;
      end
      MODE_AND: begin
        res2_nxt = {16'h0000, am & bm};
        wr2_nxt  = FW_LOGIC;
      end
      MODE_OR: begin
        res2_nxt = {16'h0000, am | bm};
        wr2_nxt  = FW_LOGIC;
      end
      MODE_XOR: begin
        res2_nxt = {16'h0000, am ^ bm};
        wr2_nxt  = FW_LOGIC;
      end
      MODE_MUL: begin
        res2_nxt = prod;
        mul2_nxt = 1'b1;
        wr2_nxt  = FW_MUL;
      end
      default: begin
        res2_nxt = 32'h0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      res2_r  <= res2_nxt;
      c2_r    <= c2_nxt;
      o2_r    <= o2_nxt;
      aux2_r  <= aux2_nxt;
      wide2_r <= wide1_r;
      mul2_r  <= mul2_nxt;
      wr2_r   <= wr2_nxt;
    end
  end

  // Flag stage.
  logic mul_fits;

  always_comb begin
    // The product fits in 16 signed bits when bits 31..15 are all equal.
    mul_fits = (res2_r[31:15] == 17'h00000) || (res2_r[31:15] == 17'h1ffff);
    c3_nxt   = mul2_r ? !mul_fits : c2_r;
    o3_nxt   = mul2_r ? !mul_fits : o2_r;
    s3_nxt   = wr2_r[FB_SIGN] & (wide2_r ? res2_r[15] : res2_r[7]);
    z3_nxt   = wr2_r[FB_ZERO] & (res2_r[15:0] == 16'h0000);
    aux3_nxt = wr2_r[FB_AUX] & aux2_r;
    p3_nxt   = wr2_r[FB_PARITY] & ~(^res2_r[7:0]);
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      res3_r <= res2_r;
      c3_r   <= c3_nxt;
      o3_r   <= o3_nxt;
      s3_r   <= s3_nxt;
      z3_r   <= z3_nxt;
      aux3_r <= aux3_nxt;
      p3_r   <= p3_nxt;
      wr3_r  <= wr2_r;
    end
  end

  assign out_valid         = v3_r;
  assign out_result        = res3_r;
  assign out_flag_carry    = c3_r;
  assign out_flag_overflow = o3_r;
  assign out_flag_sign     = s3_r;
  assign out_flag_zero     = z3_r;
  assign out_flag_aux      = aux3_r;
  assign out_flag_parity   = p3_r;
  assign out_flags_written = wr3_r;

  a_mul_c_eq_o: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_flags_written == FW_MUL) |-> (out_flag_carry == out_flag_overflow))
    else $error("multiply carry and overflow differ");

  a_logic_clears_co: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_flags_written == FW_LOGIC) |-> (!out_flag_carry && !out_flag_overflow))
    else $error("logic operation set carry or overflow");

  a_none_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_flags_written == FW_NONE) |-> (out_result == 32'h0))
    else $error("unused mode produced a nonzero result");

  a_stall_holds_stage2: assert property (@(posedge clk) disable iff (!rst_n)
    (v2_r && !en2) |=> (v2_r && $stable(res2_r)))
    else $error("execute stage item lost during stall");

endmodule
